[rtl/core/asft_pkg.sv]
// ----------------------------------------------------------------------------
// asft_pkg
// Shared types and constants for the ARP reply spoof filter table.
// ----------------------------------------------------------------------------
package asft_pkg;

    localparam logic [15:0] ARP_ETHERTYPE = 16'h0806;
    localparam logic [15:0] ARP_OP_REPLY  = 16'd2;
    localparam int          MAC_BYTES     = 6;

    localparam int MAC_W = MAC_BYTES * 8;
    localparam int IP_W  = 32;

    // depth of the queue between the front and back parts
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [2:0] {
        OUT_NOT_CHECKED = 3'd0,
        OUT_LEARNED     = 3'd1,
        OUT_UPDATED     = 3'd2,
        OUT_FULL        = 3'd3,
        OUT_SPOOF       = 3'd4
    } outcome_t;

    typedef struct packed {
        logic             checked;
        logic [MAC_W-1:0] mac;
        logic [IP_W-1:0]  ip;
    } item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_SCAN,
        B_DRAIN,
        B_DECIDE
    } back_state_t;

endpackage

[rtl/core/asft_front.sv]
// ----------------------------------------------------------------------------
// asft_front
// Accepts frame headers and classifies them as ARP replies to be checked.
// ----------------------------------------------------------------------------
module asft_front
    import asft_pkg::*;
(
    input  logic              push,
    input  logic              packet_present,
    input  logic [15:0]       ether_type,
    input  logic [15:0]       arp_opcode,
    input  logic [MAC_W-1:0]  sender_mac,
    input  logic [IP_W-1:0]   sender_ip,
    input  q_stat_t           q_stat,
    output logic              full,
    output logic              q_wr_en,
    output item_t             q_wr_item
);

    assign full    = q_stat.full;
    assign q_wr_en = push & ~q_stat.full;

    always_comb
    begin
        q_wr_item.checked = packet_present && (ether_type == ARP_ETHERTYPE)
                            && (arp_opcode == ARP_OP_REPLY);
        q_wr_item.mac     = sender_mac;
        q_wr_item.ip      = sender_ip;
    end

endmodule

[rtl/core/asft_queue.sv]
// ----------------------------------------------------------------------------
// asft_queue
// Short FIFO of classified items between the front and back parts.
// ----------------------------------------------------------------------------
module asft_queue
    import asft_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    wr_en,
    input  item_t   wr_item,
    input  logic    rd_en,
    output item_t   rd_item,
    output q_stat_t q_stat
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    item_t              slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               do_wr, do_rd;

    assign q_stat.full  = (cnt_reg == CNT_W'(QUEUE_DEPTH));
    assign q_stat.empty = (cnt_reg == '0);
    assign do_wr        = wr_en & ~q_stat.full;
    assign do_rd        = rd_en & ~q_stat.empty;
    assign rd_item      = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                          : wr_ptr_reg + PTR_W'(1);
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                          : rd_ptr_reg + PTR_W'(1);
        end
        if (do_wr && !do_rd)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (do_rd && !do_wr)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

[rtl/core/asft_back.sv]
// ----------------------------------------------------------------------------
// asft_back
// Scans the learned table for one item, updates it and posts the verdict.
// ----------------------------------------------------------------------------
module asft_back
    import asft_pkg::*;
#(
    parameter int TABLE_ENTRIES = 256
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  q_stat_t     q_stat,
    input  item_t       q_item,
    output logic        q_rd_en,
    input  logic        pop,
    output logic        empty,
    output logic        verdict,
    output logic [2:0]  outcome
);

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

    // slots are filled lowest first and never freed, so valid ones form a
    // prefix of the table and the fill count stands in for valid bits
    logic [MAC_W-1:0]   mac_mem [TABLE_ENTRIES];
    logic [IP_W-1:0]    ip_mem  [TABLE_ENTRIES];

    back_state_t        state_reg, state_next;
    item_t              cur_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   addr_reg;
    logic [CNT_W-1:0]   addr_inc;
    logic               rd_vld_reg;
    logic [IDX_W-1:0]   rd_idx_reg;
    logic [MAC_W-1:0]   rd_mac_reg;
    logic [IP_W-1:0]    rd_ip_reg;
    logic               mac_hit_reg;
    logic               ip_hit_reg;
    logic [IDX_W-1:0]   hit_idx_reg;
    logic               out_valid_reg;
    logic               verdict_reg;
    outcome_t           outcome_reg;

    logic               issue;
    logic               finish;
    logic               out_free;
    logic               tbl_full;
    logic               res_verdict;
    outcome_t           res_outcome;
    logic               mac_we;
    logic               ip_we;
    logic [IDX_W-1:0]   mac_waddr;
    logic [IDX_W-1:0]   fill_idx;
    logic [IDX_W-1:0]   rd_addr;

    assign addr_inc = addr_reg + CNT_W'(1);
    assign out_free = ~out_valid_reg | pop;
    assign tbl_full = (count_reg == CNT_W'(TABLE_ENTRIES));
    assign fill_idx = count_reg[IDX_W-1:0];
    assign rd_addr  = addr_reg[IDX_W-1:0];

    assign empty    = ~out_valid_reg;
    assign verdict  = verdict_reg;
    assign outcome  = outcome_reg;

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        q_rd_en    = 1'b0;
        issue      = 1'b0;
        finish     = 1'b0;
        unique case (state_reg)
            B_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    q_rd_en = 1'b1;
                    if (!q_item.checked || count_reg == '0)
                    begin
                        state_next = B_DECIDE;
                    end
                    else
                    begin
                        state_next = B_SCAN;
                    end
                end
            end
            B_SCAN:
            begin
                issue = 1'b1;
                if (addr_inc == count_reg)
                begin
                    state_next = B_DRAIN;
                end
            end
            B_DRAIN:
            begin
                state_next = B_DECIDE;
            end
            B_DECIDE:
            begin
                if (out_free)
                begin
                    finish     = 1'b1;
                    state_next = B_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // verdict from the scan flags
    always_comb
    begin
        res_verdict = 1'b0;
        priority if (!cur_reg.checked)
        begin
            res_outcome = OUT_NOT_CHECKED;
        end
        else if (mac_hit_reg)
        begin
            res_verdict = 1'b1;
            res_outcome = OUT_SPOOF;
        end
        else if (ip_hit_reg)
        begin
            res_outcome = OUT_UPDATED;
        end
        else if (tbl_full)
        begin
            res_outcome = OUT_FULL;
        end
        else
        begin
            res_outcome = OUT_LEARNED;
        end
    end

    assign mac_we    = finish & cur_reg.checked & ~mac_hit_reg & (ip_hit_reg | ~tbl_full);
    assign ip_we     = finish & cur_reg.checked & ~mac_hit_reg & ~ip_hit_reg & ~tbl_full;
    assign mac_waddr = ip_hit_reg ? hit_idx_reg : fill_idx;

    // table storage
    always_ff @(posedge clk)
    begin
        if (mac_we)
        begin
            mac_mem[mac_waddr] <= cur_reg.mac;
        end
        if (ip_we)
        begin
            ip_mem[fill_idx] <= cur_reg.ip;
        end
        rd_mac_reg <= mac_mem[rd_addr];
        rd_ip_reg  <= ip_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (q_rd_en)
        begin
            cur_reg <= q_item;
        end
        rd_idx_reg <= rd_addr;
    end

    // scan control and match flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            addr_reg    <= '0;
            rd_vld_reg  <= 1'b0;
            mac_hit_reg <= 1'b0;
            ip_hit_reg  <= 1'b0;
            hit_idx_reg <= '0;
        end
        else
        begin
            rd_vld_reg <= issue;
            if (q_rd_en)
            begin
                addr_reg    <= '0;
                mac_hit_reg <= 1'b0;
                ip_hit_reg  <= 1'b0;
            end
            else
            begin
                if (issue)
                begin
                    addr_reg <= addr_inc;
                end
                if (rd_vld_reg)
                begin
                    if (rd_mac_reg == cur_reg.mac)
                    begin
                        mac_hit_reg <= 1'b1;
                    end
                    // keep the lowest slot holding this IP
                    if (!ip_hit_reg && rd_ip_reg == cur_reg.ip)
                    begin
                        ip_hit_reg  <= 1'b1;
                        hit_idx_reg <= rd_idx_reg;
                    end
                end
            end
            if (ip_we)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            verdict_reg <= res_verdict;
            outcome_reg <= res_outcome;
        end
    end

endmodule

[rtl/core/arp_spoof_filter_table.sv]
// ----------------------------------------------------------------------------
// arp_spoof_filter_table
// ARP reply spoof filter with a learned IP-to-MAC table.
//
//  channel  | transfer when        | payload
//  ---------+----------------------+----------------------------------------
//  input    | push && !full        | packet_present, ether_type, arp_opcode,
//           |                      | sender_mac, sender_ip
//  result   | pop && !empty        | verdict, outcome
//
// A checked ARP reply takes these steps in the back part: one to take it from
// the queue, one table read per cycle through the single read port for each
// learned entry (at most TABLE_ENTRIES), one to compare the last read, one to
// decide and write once the result register is free. With an empty table, and
// for other frames, it goes from the queue straight to the decide step.
// Reset clears the fill count; no clearing pass is needed.
// A two-entry queue lets the front keep taking frames while the back scans;
// the result register holds a verdict until it is popped, stalling the back.
// ----------------------------------------------------------------------------
module arp_spoof_filter_table
    import asft_pkg::*;
#(
    parameter int TABLE_ENTRIES = 256
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic        packet_present,
    input  logic [15:0] ether_type,
    input  logic [15:0] arp_opcode,
    input  logic [47:0] sender_mac,
    input  logic [31:0] sender_ip,
    output logic        empty,
    input  logic        pop,
    output logic        verdict,
    output logic [2:0]  outcome
);

    q_stat_t q_stat;
    logic    q_wr_en;
    item_t   q_wr_item;
    logic    q_rd_en;
    item_t   q_rd_item;

    asft_front u_front
    (
        .push           (push),
        .packet_present (packet_present),
        .ether_type     (ether_type),
        .arp_opcode     (arp_opcode),
        .sender_mac     (sender_mac),
        .sender_ip      (sender_ip),
        .q_stat         (q_stat),
        .full           (full),
        .q_wr_en        (q_wr_en),
        .q_wr_item      (q_wr_item)
    );

    asft_queue u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_wr_en),
        .wr_item (q_wr_item),
        .rd_en   (q_rd_en),
        .rd_item (q_rd_item),
        .q_stat  (q_stat)
    );

    asft_back #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_back
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_stat  (q_stat),
        .q_item  (q_rd_item),
        .q_rd_en (q_rd_en),
        .pop     (pop),
        .empty   (empty),
        .verdict (verdict),
        .outcome (outcome)
    );

endmodule

[rtl/core/asft_checker.sv]
// ----------------------------------------------------------------------------
// asft_checker
// Port-level checks for the ARP reply spoof filter table.
// ----------------------------------------------------------------------------
module asft_checker
    import asft_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       empty,
    input logic       pop,
    input logic       verdict,
    input logic [2:0] outcome
);

    // a drop is given exactly for a spoofed reply
    a_drop_is_spoof: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (verdict == (outcome == OUT_SPOOF)))
        else $error("verdict does not agree with outcome");

    a_outcome_code: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (outcome == OUT_NOT_CHECKED || outcome == OUT_LEARNED ||
                    outcome == OUT_UPDATED || outcome == OUT_FULL ||
                    outcome == OUT_SPOOF))
        else $error("outcome holds an unused code");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(verdict) && $stable(outcome)))
        else $error("waiting result changed before transfer");

endmodule

bind arp_spoof_filter_table asft_checker u_asft_checker (.*);

[bench/arp_spoof_filter_table_tb.sv]
// ----------------------------------------------------------------------------
// arp_spoof_filter_table_tb
// Self-checking bench for the ARP reply spoof filter table. Frames are pushed
// through the input queue; every verdict popped from the result side is
// compared with a cycle-free model of the learned IP-to-MAC table. Directed
// frames cover the unchecked paths, learning, update and spoof drop; random
// phases mix well-formed replies with noise, fill the table to capacity and
// then keep hitting the full table, under several idle/stall profiles.
// ----------------------------------------------------------------------------
module arp_spoof_filter_table_tb
    import asft_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS        = 256;
    localparam int SETTLE_CYCLES = 300;

    typedef struct {
        logic     verdict;
        outcome_t outcome;
    } verdict_exp_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic        packet_present = 1'b0;
    logic [15:0] ether_type = '0;
    logic [15:0] arp_opcode = '0;
    logic [47:0] sender_mac = '0;
    logic [31:0] sender_ip = '0;
    logic        empty;
    logic        pop = 1'b0;
    logic        verdict;
    logic [2:0]  outcome;

    // learned table as the filter should hold it
    logic        learned_valid [SLOTS];
    logic [31:0] learned_ip    [SLOTS];
    logic [47:0] learned_mac   [SLOTS];
    int          learned_count = 0;

    verdict_exp_t verdict_q [$];

    int errors        = 0;
    int send_idle_pct = 0;
    int pop_stall_pct = 0;
    int hold_left     = 0;

    always #1 clk = ~clk;

    arp_spoof_filter_table #(
        .TABLE_ENTRIES (SLOTS)
    ) u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .packet_present (packet_present),
        .ether_type     (ether_type),
        .arp_opcode     (arp_opcode),
        .sender_mac     (sender_mac),
        .sender_ip      (sender_ip),
        .empty          (empty),
        .pop            (pop),
        .verdict        (verdict),
        .outcome        (outcome)
    );

    function automatic verdict_exp_t classify_frame(input logic present,
                                                    input logic [15:0] etype,
                                                    input logic [15:0] op,
                                                    input logic [47:0] mac,
                                                    input logic [31:0] ip);
        verdict_exp_t r;
        int hit;
        int free_slot;
        r.verdict = 1'b0;
        r.outcome = OUT_NOT_CHECKED;
        hit = -1;
        free_slot = -1;
        if (!present || etype != ARP_ETHERTYPE || op != ARP_OP_REPLY)
            return r;
        // known MAC anywhere in the table is a spoof, whatever its IP
        for (int i = 0; i < SLOTS; i++)
        begin
            if (learned_valid[i] && learned_mac[i] == mac)
            begin
                r.verdict = 1'b1;
                r.outcome = OUT_SPOOF;
                return r;
            end
        end
        for (int i = 0; i < SLOTS; i++)
        begin
            if (learned_valid[i])
            begin
                if (hit < 0 && learned_ip[i] == ip)
                    hit = i;
            end
            else if (free_slot < 0)
                free_slot = i;
        end
        if (hit >= 0)
        begin
            learned_mac[hit] = mac;
            r.outcome = OUT_UPDATED;
        end
        else if (free_slot >= 0)
        begin
            learned_valid[free_slot] = 1'b1;
            learned_ip[free_slot]    = ip;
            learned_mac[free_slot]   = mac;
            learned_count++;
            r.outcome = OUT_LEARNED;
        end
        else
            r.outcome = OUT_FULL;
        return r;
    endfunction

    // one input transfer; inputs move on the falling edge
    task automatic send_frame(input logic present, input logic [15:0] etype,
                              input logic [15:0] op, input logic [47:0] mac,
                              input logic [31:0] ip);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push           <= 1'b1;
        packet_present <= present;
        ether_type     <= etype;
        arp_opcode     <= op;
        sender_mac     <= mac;
        sender_ip      <= ip;
        do
            @(posedge clk);
        while (full);
        verdict_q.push_back(classify_frame(present, etype, op, mac, ip));
    endtask

    task automatic send_reply(input logic [47:0] mac, input logic [31:0] ip);
        send_frame(1'b1, ARP_ETHERTYPE, ARP_OP_REPLY, mac, ip);
    endtask

    task automatic wait_results_drained();
        @(negedge clk);
        push <= 1'b0;
        while (verdict_q.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [47:0] rand_mac();
        return {16'($urandom_range(16'hFFFF, 0)), $urandom()};
    endfunction

    // result side: pop decided on the falling edge
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            pop       <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else
            pop <= ($urandom_range(99) >= pop_stall_pct);
    end

    always @(posedge clk)
    begin : check_result
        verdict_exp_t want;
        if (rst_n && pop && !empty)
        begin
            if (verdict_q.size() == 0)
            begin
                $error("unexpected result transfer: verdict=%0d outcome=%0d",
                       verdict, outcome);
                errors++;
            end
            else
            begin
                want = verdict_q.pop_front();
                if (verdict !== want.verdict)
                begin
                    $error("verdict: expected %0d, actual %0d", want.verdict, verdict);
                    errors++;
                end
                if (outcome !== want.outcome)
                begin
                    $error("outcome: expected %0d, actual %0d", want.outcome, outcome);
                    errors++;
                end
            end
        end
    end

    task automatic test_unchecked_frames();
        send_frame(1'b0, ARP_ETHERTYPE, ARP_OP_REPLY, '1, '1);
        send_frame(1'b1, 16'h0000, ARP_OP_REPLY, '0, '0);
        send_frame(1'b1, 16'hFFFF, ARP_OP_REPLY, '1, '1);
        send_frame(1'b1, 16'h0807, ARP_OP_REPLY, 48'h0000_1111_2222, 32'h0A00_0001);
        send_frame(1'b1, ARP_ETHERTYPE, 16'd0, '1, '0);
        send_frame(1'b1, ARP_ETHERTYPE, 16'd1, '0, '1);
        send_frame(1'b1, ARP_ETHERTYPE, 16'hFFFF, '1, '1);
    endtask

    task automatic test_learn_update_spoof();
        send_reply('0, '0);                                  // learned
        send_reply('1, '1);                                  // learned
        send_reply(48'h0102_0304_0506, '0);                  // update of IP 0
        send_reply('0, '0);                                  // old MAC gone: update
        send_reply('1, 32'h0A00_0001);                       // known MAC, new IP
        send_reply('1, '1);                                  // known MAC, own IP
        send_frame(1'b0, ARP_ETHERTYPE, ARP_OP_REPLY, '1, '1); // known MAC, no frame
        send_reply(48'h0102_0304_0506, 32'h0000_0005);       // learned
        send_reply(48'h0102_0304_0506, 32'h0000_0006);       // spoof
        send_reply(48'hA5A5_5A5A_A5A5, 32'h5A5A_A5A5);       // learned
    endtask

    task automatic test_random_mix(input int count);
        int pick;
        int slot;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(99);
            slot = (learned_count > 0) ? $urandom_range(learned_count - 1) : 0;
            if (pick < 25 || learned_count == 0)
                send_reply(rand_mac(), $urandom());
            else if (pick < 50)
                send_reply(rand_mac(), learned_ip[slot]);
            else if (pick < 70)
                send_reply(learned_mac[slot],
                           ($urandom_range(3) == 0) ? learned_ip[slot] : $urandom());
            else
                send_frame(1'($urandom_range(1)),
                           ($urandom_range(2) == 0) ? ARP_ETHERTYPE : 16'($urandom()),
                           ($urandom_range(2) == 0) ? ARP_OP_REPLY : 16'($urandom()),
                           ($urandom_range(3) == 0 && learned_count > 0) ?
                               learned_mac[slot] : rand_mac(),
                           $urandom());
        end
    endtask

    task automatic run_mix_phases(input int count);
        send_idle_pct = 0;  pop_stall_pct = 0;  test_random_mix(count);
        send_idle_pct = 56; pop_stall_pct = 0;  test_random_mix(count);
        send_idle_pct = 0;  pop_stall_pct = 56; test_random_mix(count);
        send_idle_pct = 7;  pop_stall_pct = 7;  test_random_mix(count);
    endtask

    task automatic test_fill_table();
        while (learned_count < SLOTS)
            send_reply(rand_mac(), $urandom());
        for (int n = 0; n < 6; n++)
            send_reply(rand_mac(), $urandom());
    endtask

    // receiver held off long enough that the input queue backs up
    task automatic test_backpressure();
        @(negedge clk);
        push <= 1'b0;
        @(posedge clk);
        hold_left = 400;
        for (int n = 0; n < 12; n++)
        begin
            if (n % 3 == 0)
                send_reply(rand_mac(), $urandom());
            else
                send_frame(1'b0, 16'($urandom()), 16'($urandom()), rand_mac(), $urandom());
        end
    endtask

    initial
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            learned_valid[i] = 1'b0;
            learned_ip[i]    = '0;
            learned_mac[i]   = '0;
        end
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_unchecked_frames();
        test_learn_update_spoof();
        wait_results_drained();
        run_mix_phases(80);
        test_backpressure();
        wait_results_drained();
        send_idle_pct = 7;
        pop_stall_pct = 7;
        test_fill_table();
        wait_results_drained();
        run_mix_phases(100);
        test_backpressure();

        wait_results_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
